// ===== sv/sep2_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, flag codes and single-precision constants for the power-of-two pipeline.
package sep2_pkg;

	typedef enum logic [1:0] {
		FLAG_NORMAL = 2'd0,
		FLAG_UNDER  = 2'd1,
		FLAG_OVER   = 2'd2,
		FLAG_NAN    = 2'd3
	} flag_t;

	typedef struct packed {
		logic        valid;
		flag_t       flag;
		logic [31:0] spec;
		logic [31:0] f;
		logic [7:0]  ebits;
	} side_t;

	localparam logic [31:0] HALF_BITS = 32'h3F00_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [30:0] OVER_LIM  = 31'h4300_0000;
	localparam logic [30:0] UNDER_LIM = 31'h42FC_0000;
	localparam logic [7:0]  EXP_BIAS  = 8'd127;

	localparam int NCOEF = 7;

	localparam logic [31:0] COEF [NCOEF] = '{
		32'h3920_FDDE,
		32'h3AAF_9F29,
		32'h3C1D_96A6,
		32'h3D63_5774,
		32'h3E75_FDEE,
		32'h3F31_7218,
		32'h3F80_0000
	};

endpackage

// ===== sv/sep2_fadd.sv =====
`timescale 1ns / 1ps
// Three-stage single-precision adder for finite operands, rounding to nearest even.
module sep2_fadd
	import sep2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  side_t       side_in,
	output logic [31:0] sum,
	output side_t       side_out
);

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       hit;
		n   = 5'd27;
		hit = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 5'(26 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	logic        a_big;
	logic [31:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [26:0] mb_ext, ms_ext, al, mask;
	logic        st;

	always_comb begin
		a_big  = a[30:0] >= b[30:0];
		big    = a_big ? a : b;
		sml    = a_big ? b : a;
		eb     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d      = eb - es;
		mb_ext = {big[30:23] != 8'd0, big[22:0], 3'b000};
		ms_ext = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		if (d >= 8'd27) begin
			al   = 27'd0;
			mask = '1;
		end else begin
			al   = ms_ext >> d;
			mask = ~({27{1'b1}} << d);
		end
		st = |(ms_ext & mask);
	end

	logic        sign_s1, sub_s1, zs_s1;
	logic [7:0]  e_s1;
	logic [26:0] mb_s1, al_s1;
	side_t       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1 <= big[31];
		sub_s1  <= a[31] ^ b[31];
		zs_s1   <= a[31] & b[31];
		e_s1    <= eb;
		mb_s1   <= mb_ext;
		al_s1   <= {al[26:1], al[0] | st};
	end

	logic [27:0] raw;

	always_comb begin
		if (sub_s1) begin
			raw = {1'b0, mb_s1} - {1'b0, al_s1};
		end else begin
			raw = {1'b0, mb_s1} + {1'b0, al_s1};
		end
	end

	logic        sign_s2, zs_s2;
	logic [7:0]  e_s2;
	logic [27:0] raw_s2;
	logic [4:0]  lz_s2;
	side_t       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		zs_s2   <= zs_s1;
		e_s2    <= e_s1;
		raw_s2  <= raw;
		lz_s2   <= lzc27(raw[26:0]);
	end

	logic [26:0] m;
	logic [7:0]  ex;
	logic        up;
	logic [30:0] mag;
	logic [31:0] res;

	always_comb begin
		if (raw_s2[27]) begin
			m  = {raw_s2[27:2], raw_s2[1] | raw_s2[0]};
			ex = e_s2 + 8'd1;
		end else if ({3'b000, lz_s2} < e_s2) begin
			m  = raw_s2[26:0] << lz_s2;
			ex = e_s2 - {3'b000, lz_s2};
		end else begin
			m  = raw_s2[26:0] << (e_s2 - 8'd1);
			ex = 8'd0;
		end
		up  = m[2] & (m[1] | m[0] | m[3]);
		mag = {ex, m[25:3]} + {30'd0, up};
		if (raw_s2 == 28'd0) begin
			res = {zs_s2, 31'd0};
		end else begin
			res = {sign_s2, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out <= '0;
		end else begin
			side_out <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum <= res;
	end

endmodule

// ===== sv/sep2_fmul.sv =====
`timescale 1ns / 1ps
// Three-stage single-precision multiplier for finite operands, with subnormal results.
module sep2_fmul
	import sep2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  side_t       side_in,
	output logic [31:0] prod,
	output side_t       side_out
);

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       hit;
		n   = 6'd48;
		hit = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 6'(47 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	logic [23:0] ma, mb;
	logic [7:0]  ea, eb;

	always_comb begin
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	logic               sign_s1;
	logic [47:0]        p_s1;
	logic signed [10:0] eb_s1;
	side_t              side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1 <= a[31] ^ b[31];
		p_s1    <= ma * mb;
		eb_s1   <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
	end

	logic [5:0] lz;

	always_comb begin
		lz = lzc48(p_s1);
	end

	logic               sign_s2;
	logic [47:0]        p_s2;
	logic [5:0]         lz_s2;
	logic signed [10:0] e_s2;
	side_t              side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		p_s2    <= p_s1;
		lz_s2   <= lz;
		e_s2    <= eb_s1 - $signed({5'b00000, lz});
	end

	logic signed [10:0] sh;
	logic [10:0]        rsh;
	logic [47:0]        n, mask;
	logic [7:0]         ex;
	logic               st, up;
	logic [30:0]        mag;
	logic [31:0]        res;

	always_comb begin
		sh   = e_s2 + $signed({5'b00000, lz_s2}) - 11'sd1;
		rsh  = 11'(-sh);
		n    = '0;
		mask = '0;
		st   = 1'b0;
		ex   = 8'd0;
		if (e_s2 >= 11'sd1) begin
			n  = p_s2 << lz_s2;
			ex = e_s2[7:0];
		end else if (sh >= 11'sd0) begin
			n = p_s2 << sh[5:0];
		end else if (rsh >= 11'd48) begin
			st = |p_s2;
		end else begin
			n    = p_s2 >> rsh[5:0];
			mask = ~({48{1'b1}} << rsh[5:0]);
			st   = |(p_s2 & mask);
		end
		up  = n[23] & ((|n[22:0]) | st | n[24]);
		mag = {ex, n[46:24]} + {30'd0, up};
		if (p_s2 == 48'd0) begin
			res = {sign_s2, 31'd0};
		end else if (e_s2 >= 11'sd255) begin
			res = {sign_s2, INF_BITS[30:0]};
		end else begin
			res = {sign_s2, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out <= '0;
		end else begin
			side_out <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod <= res;
	end

endmodule

// ===== sv/sep2_floor.sv =====
`timescale 1ns / 1ps
// Range check, floor of the shifted argument and its negated float form, one register stage.
module sep2_floor
	import sep2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] s,
	input  side_t       side_in,
	output logic [31:0] kneg_bits,
	output side_t       side_out
);

	logic [7:0]        e;
	logic [23:0]       man, mask;
	logic [4:0]        shr;
	logic [7:0]        t;
	logic              fr;
	logic signed [8:0] k;
	logic [6:0]        km;
	logic [2:0]        pos;
	logic [23:0]       kfm;
	logic [31:0]       kf;
	side_t             nxt;

	always_comb begin
		e    = s[30:23];
		man  = {1'b1, s[22:0]};
		shr  = 5'(8'd150 - e);
		mask = '0;
		t    = 8'd0;
		fr   = 1'b0;
		if (e < EXP_BIAS) begin
			fr = s[30:0] != 31'd0;
		end else if (e <= 8'd133) begin
			t    = 8'(man >> shr);
			mask = ~({24{1'b1}} << shr);
			fr   = |(man & mask);
		end
		if (s[31]) begin
			k = -$signed({1'b0, t}) - $signed({8'd0, fr});
		end else begin
			k = $signed({1'b0, t});
		end
		km  = k[8] ? 7'(-k) : k[6:0];
		pos = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (km[i]) begin
				pos = 3'(i);
			end
		end
		kfm = {17'd0, km} << (5'd23 - {2'b00, pos});
		if (km == 7'd0) begin
			kf = 32'd0;
		end else begin
			kf = {k[8], EXP_BIAS + {5'd0, pos}, kfm[22:0]};
		end

		nxt       = side_in;
		nxt.ebits = 8'(k + 9'sd127);
		if (side_in.flag == FLAG_NORMAL) begin
			if (!s[31] && s[30:0] >= OVER_LIM) begin
				nxt.flag = FLAG_OVER;
				nxt.spec = INF_BITS;
			end else if (s[31] && s[30:0] > UNDER_LIM) begin
				nxt.flag = FLAG_UNDER;
				nxt.spec = 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out <= '0;
		end else begin
			side_out <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		kneg_bits <= {~kf[31], kf[30:0]};
	end

endmodule

// ===== sv/single_exp2_polynomial.sv =====
`timescale 1ns / 1ps
// Top level of the single-precision power-of-two pipeline.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ----------------------
//  argument  start, busy         x_bits
//  result    done (strobe)       y_bits, range_flag
//
// One transaction is accepted every cycle; busy is always low.
// The pipeline is a three-stage adder for x + 0.5, the floor stage, a
// three-stage adder for the fraction, six multiply and add pairs of three
// stages each, the three-stage scaling multiply and the output register.
// Reset clears every valid bit; results appear in order, one per transaction.
// The receiver cannot stall, so there is no back-pressure anywhere.
module single_exp2_polynomial
	import sep2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_bits,
	output logic        done,
	output logic [31:0] y_bits,
	output logic [1:0]  range_flag
);

	side_t front;

	always_comb begin
		front       = '0;
		front.valid = start;
		front.f     = x_bits;
		if (x_bits[30:23] == 8'hFF) begin
			if (x_bits[22:0] != 23'd0) begin
				front.flag = FLAG_NAN;
				front.spec = x_bits;
			end else if (!x_bits[31]) begin
				front.flag = FLAG_OVER;
				front.spec = INF_BITS;
			end else begin
				front.flag = FLAG_UNDER;
			end
		end
	end

	logic [31:0] s_bits;
	side_t       side_a;

	sep2_fadd u_add_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.a        (x_bits),
		.b        (HALF_BITS),
		.side_in  (front),
		.sum      (s_bits),
		.side_out (side_a)
	);

	logic [31:0] kneg_bits;
	side_t       side_b;

	sep2_floor u_floor (
		.clk       (clk),
		.arst_n    (arst_n),
		.s         (s_bits),
		.side_in   (side_a),
		.kneg_bits (kneg_bits),
		.side_out  (side_b)
	);

	logic [31:0] f_bits;
	side_t       side_c;

	sep2_fadd u_add_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.a        (side_b.f),
		.b        (kneg_bits),
		.side_in  (side_b),
		.sum      (f_bits),
		.side_out (side_c)
	);

	logic [31:0] acc    [NCOEF];
	side_t       side_h [NCOEF];

	assign acc[0]    = COEF[0];
	assign side_h[0] = '{valid: side_c.valid, flag: side_c.flag, spec: side_c.spec,
		f: f_bits, ebits: side_c.ebits};

	for (genvar i = 1; i < NCOEF; i++) begin : g_horner
		logic [31:0] prod;
		side_t       side_m;

		sep2_fmul u_mul (
			.clk      (clk),
			.arst_n   (arst_n),
			.a        (acc[i-1]),
			.b        (side_h[i-1].f),
			.side_in  (side_h[i-1]),
			.prod     (prod),
			.side_out (side_m)
		);

		sep2_fadd u_add (
			.clk      (clk),
			.arst_n   (arst_n),
			.a        (prod),
			.b        (COEF[i]),
			.side_in  (side_m),
			.sum      (acc[i]),
			.side_out (side_h[i])
		);
	end

	logic [31:0] y_raw;
	side_t       side_y;

	sep2_fmul u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.a        ({1'b0, side_h[NCOEF-1].ebits, 23'd0}),
		.b        (acc[NCOEF-1]),
		.side_in  (side_h[NCOEF-1]),
		.prod     (y_raw),
		.side_out (side_y)
	);

	logic        done_q;
	logic [31:0] y_q;
	logic [1:0]  flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_y.valid;
		end
	end

	always_ff @(posedge clk) begin
		flag_q <= side_y.flag;
		if (side_y.flag == FLAG_NORMAL) begin
			y_q <= y_raw;
		end else begin
			y_q <= side_y.spec;
		end
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign y_bits     = y_q;
	assign range_flag = flag_q;

	a_nan_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_flag == FLAG_NAN |-> y_bits[30:23] == 8'hFF && y_bits[22:0] != 23'd0)
		else $error("NaN flag without a NaN result");

	a_over_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_flag == FLAG_OVER |-> y_bits == INF_BITS)
		else $error("overflow flag without infinity");

	a_under_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_flag == FLAG_UNDER |-> y_bits == 32'd0)
		else $error("underflow flag without zero");

	a_normal_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_flag == FLAG_NORMAL |-> !y_bits[31] && y_bits[30:23] != 8'hFF)
		else $error("normal result is negative or not finite");

endmodule
